// ===== rtl/core/ksvt_pkg.sv =====
// ============================================================================
// ksvt_pkg
// Shared types and codes for the keyed sensor value table: entry layout,
// action and status codes, table sizing.
// ============================================================================
package ksvt_pkg;

    localparam int TABLE_DEPTH  = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int MAX_RESULTS  = 32;

    // counters that must also hold the depth itself
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int LIM_W = 6;

    // action codes
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_UPSERT = 2'd1;
    localparam logic [1:0] ACT_LIST   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // one stored table entry
    typedef struct packed {
        logic [63:0]             dev;
        logic [7:0]              ep;
        logic [15:0]             clu;
        logic [15:0]             att;
        logic [PAYLOAD_BITS-1:0] val;
    } entry_t;

endpackage

// ===== rtl/core/keyed_sensor_value_table_core.sv =====
// ============================================================================
// keyed_sensor_value_table_core
// Keyed sensor value table: a ring of entry cells that rotates one full turn
// per valid upsert or nonzero-limit list, with the head compared each cycle.
// ============================================================================
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  req     | req_valid/req_ready  | action device_id endpoint cluster attribute
//          |                      | payload max_entries
//  rsp     | rsp_valid/rsp_ready  | status has_entry out_endpoint out_cluster
//          |                      | out_attribute out_payload last
//
//  Clear, rejected, unknown-action and zero-limit list transactions go from
//  idle straight to the finish state. Other upserts and lists turn the ring
//  once, one cell per cycle unless a list hit stalls it, so the head sees
//  every slot in table order and ends aligned.
//  A list hit stalls the ring while the previous hit waits for a free
//  response register, and the final response waits for it likewise; the
//  response register lets a new request in early.
//  Reset clears the ready flag and entry count; the cells are not cleared.
//
module keyed_sensor_value_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  action,
    input  logic [63:0] device_id,
    input  logic [7:0]  endpoint,
    input  logic [15:0] cluster,
    input  logic [15:0] attribute,
    input  logic [31:0] payload,
    input  logic [5:0]  max_entries,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [1:0]  status,
    output logic        has_entry,
    output logic [7:0]  out_endpoint,
    output logic [15:0] out_cluster,
    output logic [15:0] out_attribute,
    output logic [31:0] out_payload,
    output logic        last
);
    import ksvt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    // control registers
    state_t           state_reg,     state_next;
    logic             ready_reg,     ready_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic [CNT_W-1:0] idx_reg,       idx_next;
    logic [LIM_W-1:0] n_reg,         n_next;
    logic             matched_reg,   matched_next;
    logic             pend_has_reg,  pend_has_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // payload registers
    logic [1:0]       act_reg,       act_next;
    entry_t           key_reg,       key_next;
    logic [LIM_W-1:0] lim_reg,       lim_next;
    logic [1:0]       res_st_reg,    res_st_next;
    entry_t           pend_reg,      pend_next;
    logic [1:0]       status_reg,    status_next;
    logic             has_reg,       has_next;
    logic [7:0]       ep_reg,        ep_next;
    logic [15:0]      clu_reg,       clu_next;
    logic [15:0]      att_reg,       att_next;
    logic [31:0]      val_reg,       val_next;
    logic             last_reg,      last_next;

    // ring wiring
    entry_t chain [TABLE_DEPTH];
    entry_t tail_in;
    entry_t head;
    logic   step;

    logic req_fire;
    logic out_free;
    logic head_valid;
    logic key_hit;
    logic list_hit;
    logic append_now;
    logic is_upsert;
    logic stall;
    logic last_step;

    // build the ring: cell k takes from cell k+1, the tail from the head path
    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        entry_t din_k;
        if (k == TABLE_DEPTH - 1)
        begin : g_tail
            assign din_k = tail_in;
        end
        else
        begin : g_mid
            assign din_k = chain[k+1];
        end
        ksvt_cell u_cell (
            .clk   (clk),
            .shift (step),
            .din   (din_k),
            .dout  (chain[k])
        );
    end

    assign head      = chain[0];
    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // compare the head slot against the held request
    always_comb
    begin
        is_upsert  = (act_reg == ACT_UPSERT);
        head_valid = (idx_reg < count_reg);
        key_hit    = head_valid && (head.dev == key_reg.dev) && (head.ep == key_reg.ep)
                     && (head.clu == key_reg.clu) && (head.att == key_reg.att);
        list_hit   = head_valid && (head.dev == key_reg.dev) && (n_reg < lim_reg);
        append_now = (idx_reg == count_reg) && !matched_reg
                     && (count_reg != CNT_W'(TABLE_DEPTH));
        stall      = !is_upsert && list_hit && pend_has_reg && !out_free;
        step       = (state_reg == S_SCAN) && !stall;
        last_step  = (idx_reg == CNT_W'(TABLE_DEPTH - 1));
    end

    // feed the tail: pass the head on, rewritten on an upsert hit or append
    always_comb
    begin
        tail_in = head;
        if (is_upsert && key_hit)
        begin
            tail_in.val = key_reg.val;
        end
        else if (is_upsert && append_now)
        begin
            tail_in = key_reg;
        end
    end

    // sequence transactions and load the response register
    always_comb
    begin
        state_next     = state_reg;
        ready_next     = ready_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        matched_next   = matched_reg;
        pend_has_next  = pend_has_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        lim_next       = lim_reg;
        res_st_next    = res_st_reg;
        pend_next      = pend_reg;
        status_next    = status_reg;
        has_next       = has_reg;
        ep_next        = ep_reg;
        clu_next       = clu_reg;
        att_next       = att_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    act_next      = action;
                    key_next.dev  = device_id;
                    key_next.ep   = endpoint;
                    key_next.clu  = cluster;
                    key_next.att  = attribute;
                    key_next.val  = payload[PAYLOAD_BITS-1:0];
                    lim_next      = (max_entries > LIM_W'(MAX_RESULTS))
                                    ? LIM_W'(MAX_RESULTS) : max_entries;
                    idx_next      = '0;
                    n_next        = '0;
                    matched_next  = 1'b0;
                    pend_has_next = 1'b0;
                    res_st_next   = ST_OK;
                    state_next    = S_FINISH;
                    case (action)
                        ACT_CLEAR:
                        begin
                            ready_next = 1'b1;
                            count_next = '0;
                        end
                        ACT_UPSERT:
                        begin
                            if (!ready_reg || (device_id == 64'd0))
                                res_st_next = ST_INVALID;
                            else
                                state_next = S_SCAN;
                        end
                        ACT_LIST:
                        begin
                            if (!ready_reg)
                                res_st_next = ST_INVALID;
                            else if (max_entries != '0)
                                state_next = S_SCAN;
                        end
                        default:
                        begin
                            res_st_next = ST_INVALID;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (step)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (is_upsert)
                    begin
                        if (key_hit)
                            matched_next = 1'b1;
                        if (append_now)
                        begin
                            matched_next = 1'b1;
                            count_next   = count_reg + 1'b1;
                        end
                        if (last_step)
                            res_st_next = (matched_reg || key_hit || append_now)
                                          ? ST_OK : ST_FULL;
                    end
                    else if (list_hit)
                    begin
                        // release the previous hit, keep the new one pending
                        if (pend_has_reg)
                        begin
                            rsp_valid_next = 1'b1;
                            status_next    = ST_OK;
                            has_next       = 1'b1;
                            ep_next        = pend_reg.ep;
                            clu_next       = pend_reg.clu;
                            att_next       = pend_reg.att;
                            val_next       = 32'(pend_reg.val);
                            last_next      = 1'b0;
                        end
                        pend_next     = head;
                        pend_has_next = 1'b1;
                        n_next        = n_reg + 1'b1;
                    end
                    if (last_step)
                        state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    last_next      = 1'b1;
                    if (pend_has_reg)
                    begin
                        status_next = ST_OK;
                        has_next    = 1'b1;
                        ep_next     = pend_reg.ep;
                        clu_next    = pend_reg.clu;
                        att_next    = pend_reg.att;
                        val_next    = 32'(pend_reg.val);
                    end
                    else
                    begin
                        status_next = res_st_reg;
                        has_next    = 1'b0;
                        ep_next     = '0;
                        clu_next    = '0;
                        att_next    = '0;
                        val_next    = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ready_reg     <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            matched_reg   <= 1'b0;
            pend_has_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            matched_reg   <= matched_next;
            pend_has_reg  <= pend_has_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // request, pending hit and response payload
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        key_reg    <= key_next;
        lim_reg    <= lim_next;
        res_st_reg <= res_st_next;
        pend_reg   <= pend_next;
        status_reg <= status_next;
        has_reg    <= has_next;
        ep_reg     <= ep_next;
        clu_reg    <= clu_next;
        att_reg    <= att_next;
        val_reg    <= val_next;
        last_reg   <= last_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign has_entry     = has_reg;
    assign out_endpoint  = ep_reg;
    assign out_cluster   = clu_reg;
    assign out_attribute = att_reg;
    assign out_payload   = val_reg;
    assign last          = last_reg;

    // entry count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // a list never holds more hits than its limit
    a_list_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (n_reg <= lim_reg))
        else $error("list hit count beyond limit");

    // a completed turn of the ring always leads to the final response
    a_turn_done: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last_step) |=> (state_reg == S_FINISH))
        else $error("ring turn did not end the scan");

    // an accepted request always leaves idle
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != S_IDLE))
        else $error("request accepted without leaving idle");

    // a response without an entry is always the final one
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !has_reg) |-> last_reg)
        else $error("empty response not marked last");

endmodule

// ===== rtl/core/ksvt_cell.sv =====
// ============================================================================
// ksvt_cell
// One storage cell of the entry ring. Takes the entry of its neighbor when
// the ring advances and holds it otherwise.
// ============================================================================
module ksvt_cell (
    input  logic            clk,
    input  logic            shift,
    input  ksvt_pkg::entry_t din,
    output ksvt_pkg::entry_t dout
);
    import ksvt_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // advance or hold
    always_comb
    begin
        entry_next = shift ? din : entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign dout = entry_reg;

endmodule

// ===== tb/keyed_sensor_value_table_checker.sv =====
// ============================================================================
// keyed_sensor_value_table_checker
// Watches the request and response channels of the keyed sensor value table,
// keeps its own copy of the table, predicts the responses of every accepted
// request and compares each accepted response field by field, in order.
// ============================================================================
module keyed_sensor_value_table_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic [1:0]  action,
    input  logic [63:0] device_id,
    input  logic [7:0]  endpoint,
    input  logic [15:0] cluster,
    input  logic [15:0] attribute,
    input  logic [31:0] payload,
    input  logic [5:0]  max_entries,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [1:0]  status,
    input  logic        has_entry,
    input  logic [7:0]  out_endpoint,
    input  logic [15:0] out_cluster,
    input  logic [15:0] out_attribute,
    input  logic [31:0] out_payload,
    input  logic        last,
    output int          fail_count,
    output int          pending_count
);

    timeunit 1ns;
    timeprecision 1ps;

    import ksvt_pkg::*;

    localparam int PRINT_CAP = 50;

    typedef struct {
        logic [1:0]  status;
        logic        has_entry;
        logic [7:0]  ep;
        logic [15:0] clu;
        logic [15:0] att;
        logic [31:0] val;
        logic        last;
    } table_rsp_t;

    // mirror of the table
    logic        table_ready;
    int unsigned entry_count;
    entry_t      entry_store [TABLE_DEPTH];

    // responses still owed by the block, oldest first
    table_rsp_t  table_rsp_q [$];

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_CAP)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic void queue_rsp(input logic [1:0] st, input logic has,
                                      input entry_t e, input logic lst);
        table_rsp_t r;
        r.status    = st;
        r.has_entry = has;
        r.ep        = has ? e.ep  : '0;
        r.clu       = has ? e.clu : '0;
        r.att       = has ? e.att : '0;
        r.val       = has ? e.val : '0;
        r.last      = lst;
        table_rsp_q.push_back(r);
    endfunction

    // Update the table mirror for one request and queue its responses
    function automatic void apply_table_request(input logic [1:0] act,
                                                input logic [63:0] dev,
                                                input logic [7:0] ep,
                                                input logic [15:0] clu,
                                                input logic [15:0] att,
                                                input logic [31:0] pl,
                                                input logic [5:0] lim);
        entry_t      blank;
        int          hit_idx;
        int unsigned cap;
        int unsigned hits;
        blank   = '0;
        hit_idx = -1;
        hits    = 0;
        case (act)
            ACT_CLEAR:
            begin
                table_ready = 1'b1;
                entry_count = 0;
                queue_rsp(ST_OK, 1'b0, blank, 1'b1);
            end
            ACT_UPSERT:
            begin
                if (!table_ready || dev == '0)
                begin
                    queue_rsp(ST_INVALID, 1'b0, blank, 1'b1);
                end
                else
                begin
                    // find the first slot with the full key
                    for (int i = 0; i < int'(entry_count); i++)
                    begin
                        if (hit_idx < 0 && entry_store[i].dev == dev &&
                            entry_store[i].ep == ep && entry_store[i].clu == clu &&
                            entry_store[i].att == att)
                        begin
                            hit_idx = i;
                        end
                    end
                    if (hit_idx >= 0)
                    begin
                        entry_store[hit_idx].val = pl;
                        queue_rsp(ST_OK, 1'b0, blank, 1'b1);
                    end
                    else if (entry_count >= TABLE_DEPTH)
                    begin
                        queue_rsp(ST_FULL, 1'b0, blank, 1'b1);
                    end
                    else
                    begin
                        entry_store[entry_count] = '{dev: dev, ep: ep, clu: clu,
                                                     att: att, val: pl};
                        entry_count++;
                        queue_rsp(ST_OK, 1'b0, blank, 1'b1);
                    end
                end
            end
            ACT_LIST:
            begin
                if (!table_ready)
                begin
                    queue_rsp(ST_INVALID, 1'b0, blank, 1'b1);
                end
                else
                begin
                    cap = (lim > MAX_RESULTS) ? MAX_RESULTS : lim;
                    for (int i = 0; i < int'(entry_count) && hits < cap; i++)
                    begin
                        if (entry_store[i].dev == dev)
                        begin
                            queue_rsp(ST_OK, 1'b1, entry_store[i], 1'b0);
                            hits++;
                        end
                    end
                    // flag the final listed entry, or give one empty result
                    if (hits == 0)
                    begin
                        queue_rsp(ST_OK, 1'b0, blank, 1'b1);
                    end
                    else
                    begin
                        table_rsp_q[$].last = 1'b1;
                    end
                end
            end
            default:
            begin
                queue_rsp(ST_INVALID, 1'b0, blank, 1'b1);
            end
        endcase
    endfunction

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
        end
    endtask

    // Compare one accepted response against the oldest expectation
    task automatic check_response();
        table_rsp_t want;
        if (table_rsp_q.size() == 0)
        begin
            report_mismatch("response with no request outstanding");
        end
        else
        begin
            want = table_rsp_q.pop_front();
            check_field("status", 64'(status), 64'(want.status));
            check_field("has_entry", 64'(has_entry), 64'(want.has_entry));
            check_field("out_endpoint", 64'(out_endpoint), 64'(want.ep));
            check_field("out_cluster", 64'(out_cluster), 64'(want.clu));
            check_field("out_attribute", 64'(out_attribute), 64'(want.att));
            check_field("out_payload", 64'(out_payload), 64'(want.val));
            check_field("last", 64'(last), 64'(want.last));
        end
    endtask

    // Predict on each request transaction, compare on each response transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_ready = 1'b0;
            entry_count = 0;
            table_rsp_q.delete();
            pending_count = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                apply_table_request(action, device_id, endpoint, cluster, attribute,
                                    payload, max_entries);
            end
            if (rsp_valid && rsp_ready)
            begin
                check_response();
            end
            pending_count = table_rsp_q.size();
        end
    end

endmodule

// ===== tb/keyed_sensor_value_table_core_tb.sv =====
// ============================================================================
// keyed_sensor_value_table_core_tb
// Drives clear, upsert and list requests into the keyed sensor value table:
// a directed opening over the corner cases, a table fill past capacity, then
// random rounds of clear plus mixed upserts and lists under varying idling
// and back-pressure. The checker beside the block predicts and compares.
// ============================================================================
module keyed_sensor_value_table_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ksvt_pkg::*;

    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam int ITEM_TARGET    = 220;
    localparam int DRAIN_CYCLES   = 64;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int POOL_SIZE      = 3;

    typedef struct {
        logic [63:0] dev;
        logic [7:0]  ep;
        logic [15:0] clu;
        logic [15:0] att;
    } entry_key_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [1:0]  action = ACT_CLEAR;
    logic [63:0] device_id = '0;
    logic [7:0]  endpoint = '0;
    logic [15:0] cluster = '0;
    logic [15:0] attribute = '0;
    logic [31:0] payload = '0;
    logic [5:0]  max_entries = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [1:0]  status;
    logic        has_entry;
    logic [7:0]  out_endpoint;
    logic [15:0] out_cluster;
    logic [15:0] out_attribute;
    logic [31:0] out_payload;
    logic        last;

    int fail_count;
    int pending_count;

    int send_idle_pct = 24;
    int rcv_idle_pct  = 66;
    int hold_left     = 0;
    logic hold_start  = 1'b0;
    int items_sent    = 0;
    int stall_cycles  = 0;

    logic [63:0] dev_pool [POOL_SIZE];
    entry_key_t  round_keys [$];

    keyed_sensor_value_table_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .action        (action),
        .device_id     (device_id),
        .endpoint      (endpoint),
        .cluster       (cluster),
        .attribute     (attribute),
        .payload       (payload),
        .max_entries   (max_entries),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .has_entry     (has_entry),
        .out_endpoint  (out_endpoint),
        .out_cluster   (out_cluster),
        .out_attribute (out_attribute),
        .out_payload   (out_payload),
        .last          (last)
    );

    keyed_sensor_value_table_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .action        (action),
        .device_id     (device_id),
        .endpoint      (endpoint),
        .cluster       (cluster),
        .attribute     (attribute),
        .payload       (payload),
        .max_entries   (max_entries),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .has_entry     (has_entry),
        .out_endpoint  (out_endpoint),
        .out_cluster   (out_cluster),
        .out_attribute (out_attribute),
        .out_payload   (out_payload),
        .last          (last),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #5 clk = ~clk;

    // Drive response ready: honor a requested hold-off, else idle at random
    always @(negedge clk)
    begin
        if (hold_start)
        begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Abort when no transaction moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d responses outstanding", pending_count);
                $display("FAILED: results differ");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    function automatic logic [63:0] rand_dev();
        return {$urandom(), $urandom()};
    endfunction

    // Offer one request transaction and hold it until accepted
    task automatic send_req(input logic [1:0] act, input logic [63:0] dev,
                            input logic [7:0] ep, input logic [15:0] clu,
                            input logic [15:0] att, input logic [31:0] pl,
                            input logic [5:0] lim);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid   <= 1'b1;
        action      <= act;
        device_id   <= dev;
        endpoint    <= ep;
        cluster     <= clu;
        attribute   <= att;
        payload     <= pl;
        max_entries <= lim;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        if (act != ACT_RESERVED)
        begin
            items_sent++;
        end
    endtask

    // Drop valid and wait until every owed response has come back
    task automatic drain_responses();
        @(negedge clk);
        req_valid <= 1'b0;
        wait (pending_count == 0);
    endtask

    task automatic send_clear();
        send_req(ACT_CLEAR, rand_dev(), 8'($urandom), 16'($urandom), 16'($urandom),
                 $urandom(), 6'($urandom));
        round_keys.delete();
    endtask

    task automatic send_upsert(input entry_key_t k);
        send_req(ACT_UPSERT, k.dev, k.ep, k.clu, k.att, $urandom(), 6'($urandom));
        round_keys.push_back(k);
    endtask

    // Pick a list limit: mostly small, sometimes anywhere in the field
    function automatic logic [5:0] rand_limit();
        if ($urandom_range(99) < 45)
        begin
            return 6'($urandom_range(0, 63));
        end
        return 6'($urandom_range(0, 6));
    endfunction

    // One round: clear, then mostly well-formed upserts and lists with noise
    task automatic run_round(input int n_ops);
        entry_key_t  k;
        int          r;
        logic [63:0] dev;
        send_clear();
        for (int n = 0; n < n_ops; n++)
        begin
            r = $urandom_range(99);
            if (r < 55)
            begin
                // reuse an earlier key now and then to hit the update path
                if (round_keys.size() > 0 && $urandom_range(99) < 25)
                begin
                    k = round_keys[$urandom_range(round_keys.size() - 1)];
                end
                else
                begin
                    k.dev = ($urandom_range(99) < 80) ?
                            dev_pool[$urandom_range(POOL_SIZE - 1)] : rand_dev();
                    k.ep  = ($urandom_range(1)) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                    k.clu = 16'($urandom);
                    k.att = 16'($urandom);
                end
                send_upsert(k);
            end
            else if (r < 90)
            begin
                dev = ($urandom_range(99) < 80) ? dev_pool[$urandom_range(POOL_SIZE - 1)] :
                      ($urandom_range(1) ? 64'd0 : rand_dev());
                send_req(ACT_LIST, dev, 8'($urandom), 16'($urandom), 16'($urandom),
                         $urandom(), rand_limit());
            end
            else if (r < 95)
            begin
                send_req(ACT_RESERVED, rand_dev(), 8'($urandom), 16'($urandom),
                         16'($urandom), $urandom(), 6'($urandom));
            end
            else
            begin
                send_req(ACT_UPSERT, 64'd0, 8'($urandom), 16'($urandom), 16'($urandom),
                         $urandom(), 6'($urandom));
            end
        end
    endtask

    initial
    begin
        entry_key_t  k;
        logic [63:0] ones;
        int          phase;
        ones  = '1;
        phase = 1;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            dev_pool[i] = rand_dev();
            if (dev_pool[i] == '0)
            begin
                dev_pool[i] = 64'd1;
            end
        end

        // hold reset, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: requests before the first clear are rejected
        send_req(ACT_UPSERT, ones, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 6'h3F);
        send_req(ACT_LIST, ones, 8'h00, 16'h0000, 16'h0000, 32'h0, 6'h3F);
        send_req(ACT_RESERVED, ones, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 6'h3F);
        send_clear();

        // directed: zero device, extreme keys, update of an existing key
        send_req(ACT_UPSERT, 64'd0, 8'h12, 16'h3456, 16'h789A, 32'hDEAD_BEEF, 6'd0);
        send_upsert('{dev: ones, ep: 8'hFF, clu: 16'hFFFF, att: 16'hFFFF});
        send_req(ACT_UPSERT, 64'd1, 8'h00, 16'h0000, 16'h0000, 32'h0, 6'd0);
        send_req(ACT_UPSERT, ones, 8'hFF, 16'hFFFF, 16'hFFFF, 32'h1234_5678, 6'd0);
        send_req(ACT_UPSERT, ones, 8'h00, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 6'd0);

        // directed: list limits above the cap, of one, of zero, and misses
        send_req(ACT_LIST, ones, 8'h00, 16'h0000, 16'h0000, 32'h0, 6'h3F);
        send_req(ACT_LIST, ones, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 6'd1);
        send_req(ACT_LIST, ones, 8'h00, 16'h0000, 16'h0000, 32'h0, 6'd0);
        send_req(ACT_LIST, 64'd0, 8'h00, 16'h0000, 16'h0000, 32'h0, 6'd32);
        send_req(ACT_LIST, 64'd5, 8'h00, 16'h0000, 16'h0000, 32'h0, 6'd32);
        send_req(ACT_LIST, 64'd1, 8'h00, 16'h0000, 16'h0000, 32'h0, 6'd32);
        send_req(ACT_RESERVED, 64'd0, 8'h00, 16'h0000, 16'h0000, 32'h0, 6'd0);
        send_clear();
        send_req(ACT_LIST, ones, 8'h00, 16'h0000, 16'h0000, 32'h0, 6'd33);
        drain_responses();

        // fill the table past capacity, update while full, list all of it
        send_clear();
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
        begin
            k.dev = dev_pool[0];
            k.ep  = 8'(i);
            k.clu = 16'($urandom);
            k.att = 16'($urandom);
            send_upsert(k);
        end
        send_upsert(round_keys[3]);
        send_req(ACT_LIST, dev_pool[0], 8'h00, 16'h0000, 16'h0000, 32'h0, 6'h3F);
        send_req(ACT_LIST, dev_pool[0], 8'h00, 16'h0000, 16'h0000, 32'h0, 6'd32);
        send_req(ACT_LIST, dev_pool[0], 8'h00, 16'h0000, 16'h0000, 32'h0, 6'd5);

        // random rounds; switch idling between phases once drained
        while (items_sent < ITEM_TARGET)
        begin
            if (phase == 1 && items_sent >= 90)
            begin
                drain_responses();
                phase         = 2;
                send_idle_pct = 66;
                rcv_idle_pct  = 24;
            end
            else if (phase == 2 && items_sent >= 155)
            begin
                drain_responses();
                phase         = 3;
                send_idle_pct = 0;
                rcv_idle_pct  = 0;
                // stall the receiver while requests keep coming
                hold_start    = 1'b1;
            end
            run_round($urandom_range(10, 45));
        end

        // let the last responses out, then a margin for strays
        drain_responses();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ksvt_pkg.sv
rtl/core/ksvt_cell.sv
rtl/core/keyed_sensor_value_table_core.sv
tb/keyed_sensor_value_table_checker.sv
tb/keyed_sensor_value_table_core_tb.sv
